@@ hdl/drr_pkg.sv @@
// Shared types, constants and power-of-ten table for the decimal rescaler.
`default_nettype none
package drr_pkg;

  typedef struct packed {
    logic signed [63:0] significand;
    logic signed [31:0] scale;
    logic signed [31:0] target_scale;
    logic [2:0]         rounding_mode;
  } drr_in_t;

  typedef struct packed {
    logic signed [63:0] result_significand;
    logic signed [31:0] result_scale;
    logic [1:0]         status;
  } drr_out_t;

  localparam logic [2:0] RM_UP          = 3'd0;
  localparam logic [2:0] RM_DOWN        = 3'd1;
  localparam logic [2:0] RM_CEILING     = 3'd2;
  localparam logic [2:0] RM_FLOOR       = 3'd3;
  localparam logic [2:0] RM_HALF_UP     = 3'd4;
  localparam logic [2:0] RM_HALF_DOWN   = 3'd5;
  localparam logic [2:0] RM_HALF_EVEN   = 3'd6;
  localparam logic [2:0] RM_UNNECESSARY = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SATURATED = 2'd1;
  localparam logic [1:0] ST_INEXACT   = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef enum logic [2:0] {
    OP_PASS = 3'b001,
    OP_MUL  = 3'b010,
    OP_DIV  = 3'b100
  } drr_op_t;

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    begin
      case (n)
        5'd0:  p = 64'd1;
        5'd1:  p = 64'd10;
        5'd2:  p = 64'd100;
        5'd3:  p = 64'd1000;
        5'd4:  p = 64'd10000;
        5'd5:  p = 64'd100000;
        5'd6:  p = 64'd1000000;
        5'd7:  p = 64'd10000000;
        5'd8:  p = 64'd100000000;
        5'd9:  p = 64'd1000000000;
        5'd10: p = 64'd10000000000;
        5'd11: p = 64'd100000000000;
        5'd12: p = 64'd1000000000000;
        5'd13: p = 64'd10000000000000;
        5'd14: p = 64'd100000000000000;
        5'd15: p = 64'd1000000000000000;
        5'd16: p = 64'd10000000000000000;
        5'd17: p = 64'd100000000000000000;
        5'd18: p = 64'd1000000000000000000;
        default: p = 64'd1;
      endcase
      return p;
    end
  endfunction

  // Bookkeeping that travels alongside the arithmetic.
  typedef struct packed {
    drr_op_t            op;
    logic               neg;
    logic [4:0]         step;
    logic [2:0]         mode;
    logic signed [63:0] sig;
    logic signed [31:0] scale;
    logic signed [31:0] target_scale;
  } drr_ctl_t;

endpackage
`default_nettype wire

@@ hdl/drr_digit.sv @@
// One pipeline stage that divides the running magnitude by ten, or multiplies it by ten.
`default_nettype none
module drr_digit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_in,
  input  wire logic [4:0]            idx,
  input  wire drr_pkg::drr_ctl_t     ctl_in,
  input  wire logic [63:0]           mag_in,
  input  wire logic                  sticky_in,
  input  wire logic [3:0]            last_in,
  input  wire logic                  ovf_in,
  output logic                       vld_out,
  output drr_pkg::drr_ctl_t          ctl_out,
  output logic [63:0]                mag_out,
  output logic                       sticky_out,
  output logic [3:0]                 last_out,
  output logic                       ovf_out
);
  import drr_pkg::*;

  logic        act;
  logic [63:0] q;
  logic [3:0]  r;
  logic [63:0] t0, t1, t2, t3, t4, qe, re;
  logic        adj;
  logic [67:0] prod;
  logic        vld_r;
  drr_ctl_t    ctl_r;
  logic [63:0] mag_r, mag_nxt;
  logic        sticky_r, sticky_nxt, ovf_r, ovf_nxt;
  logic [3:0]  last_r, last_nxt;

  // Division by ten as a shift-and-add estimate of 0.8 * n, then a shift by three.
  // The estimate is at most one below the true quotient, so one correction step
  // on the remainder is enough.
  always_comb begin
    t0 = (mag_in >> 1) + (mag_in >> 2);
    t1 = t0 + (t0 >> 4);
    t2 = t1 + (t1 >> 8);
    t3 = t2 + (t2 >> 16);
    t4 = t3 + (t3 >> 32);
    qe = t4 >> 3;
    re = mag_in - ((qe << 3) + (qe << 1));
  end

  assign adj  = re > 64'd9;
  assign q    = adj ? qe + 64'd1 : qe;
  assign r    = adj ? 4'(re - 64'd10) : re[3:0];
  assign prod = ({4'd0, mag_in} << 3) + ({4'd0, mag_in} << 1);
  assign act  = idx < ctl_in.step;

  always_comb begin
    mag_nxt    = mag_in;
    sticky_nxt = sticky_in;
    last_nxt   = last_in;
    ovf_nxt    = ovf_in;
    if (act && ctl_in.op == OP_DIV) begin
      mag_nxt    = q;
      sticky_nxt = sticky_in | (last_in != 4'd0);
      last_nxt   = r;
    end else if (act && ctl_in.op == OP_MUL && !ovf_in) begin
      mag_nxt = prod[63:0];
      ovf_nxt = prod[67:64] != 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      ctl_r    <= ctl_in;
      mag_r    <= mag_nxt;
      sticky_r <= sticky_nxt;
      last_r   <= last_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign vld_out    = vld_r;
  assign ctl_out    = ctl_r;
  assign mag_out    = mag_r;
  assign sticky_out = sticky_r;
  assign last_out   = last_r;
  assign ovf_out    = ovf_r;
endmodule
`default_nettype wire

@@ hdl/drr_round.sv @@
// Final stage: applies rounding, saturation and sign, and forms the result transaction.
`default_nettype none
module drr_round (
  input  wire drr_pkg::drr_ctl_t ctl,
  input  wire logic [63:0]       mag,
  input  wire logic              sticky,
  input  wire logic [3:0]        last,
  input  wire logic              ovf,
  output drr_pkg::drr_out_t      res
);
  import drr_pkg::*;

  logic        nz, away, tie_gt, tie_eq, sat;
  logic [63:0] q, lim;

  always_comb begin
    // last is the most significant discarded digit, sticky the rest.
    nz     = (last != 4'd0) || sticky;
    tie_gt = (last > 4'd5) || (last == 4'd5 && sticky);
    tie_eq = (last == 4'd5) && !sticky;
    away   = 1'b0;
    q      = mag;
    res.result_scale       = ctl.target_scale;
    res.status             = ST_OK;
    res.result_significand = ctl.sig;
    lim = ctl.neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    sat = ovf || (mag > lim);
    case (ctl.mode)
      RM_UP:        away = nz;
      RM_DOWN:      away = 1'b0;
      RM_CEILING:   away = nz && !ctl.neg;
      RM_FLOOR:     away = nz && ctl.neg;
      RM_HALF_UP:   away = tie_gt || tie_eq;
      RM_HALF_DOWN: away = tie_gt;
      RM_HALF_EVEN: away = tie_gt || (tie_eq && mag[0]);
      default:      away = 1'b0;
    endcase
    case (ctl.op)
      OP_MUL: begin
        if (sat) begin
          res.result_significand = lim;
          res.status             = ST_SATURATED;
        end else begin
          res.result_significand = ctl.neg ? 64'd0 - mag : mag;
        end
      end
      OP_DIV: begin
        if (ctl.mode == RM_UNNECESSARY && nz) begin
          q          = 64'd0;
          res.status = ST_INEXACT;
        end else begin
          q = mag + {63'd0, away};
        end
        res.result_significand = ctl.neg ? 64'd0 - q : q;
      end
      default: begin
        if (ctl.step != 5'd0) begin
          res.result_scale = ctl.scale;
          res.status       = ST_RANGE;
        end
      end
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/decimal_rescale_rounded.sv @@
// Decimal rescaler: moves a signed 64-bit significand to a new scale, multiplying by
// a power of ten with saturation when the scale rises and dividing with one of eight
// rounding modes when it falls. Steps of MAX_STEP_PLUS_ONE or more digits in either
// direction return the input with status 3. Fully pipelined: one transaction is taken
// every cycle unless the output stalls; each passes through a decode stage, one stage
// per decimal digit of the step, and an output register. Back-pressure stalls every
// stage together.
`default_nettype none
module decimal_rescale_rounded #(
  parameter int MAX_STEP_PLUS_ONE = 19
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire drr_pkg::drr_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output drr_pkg::drr_out_t      out_data
);
  import drr_pkg::*;

  localparam int NST = MAX_STEP_PLUS_ONE - 1;

  logic en;
  logic signed [32:0] diff;
  logic [63:0] mag0;
  drr_ctl_t ctl0;

  logic        vld   [NST+1];
  drr_ctl_t    ctl   [NST+1];
  logic [63:0] mag   [NST+1];
  logic        stk   [NST+1];
  logic [3:0]  lst   [NST+1];
  logic        ovf   [NST+1];

  logic     vld0_r, out_valid_r;
  drr_ctl_t ctl0_r;
  logic [63:0] mag0_r;
  drr_out_t res, out_data_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    diff = 33'(in_data.target_scale) - 33'(in_data.scale);
    ctl0.neg          = in_data.significand[63];
    ctl0.mode         = in_data.rounding_mode;
    ctl0.sig          = in_data.significand;
    ctl0.scale        = in_data.scale;
    ctl0.target_scale = in_data.target_scale;
    ctl0.op           = OP_PASS;
    ctl0.step         = 5'd0;
    if (diff > 33'sd0 && diff < 33'(MAX_STEP_PLUS_ONE)) begin
      ctl0.op   = OP_MUL;
      ctl0.step = diff[4:0];
    end else if (diff < 33'sd0 && -diff < 33'(MAX_STEP_PLUS_ONE)) begin
      ctl0.op   = OP_DIV;
      ctl0.step = 5'(-diff);
    end else if (diff != 33'sd0) begin
      ctl0.step = 5'd1;
    end
    mag0 = in_data.significand[63] ? 64'd0 - in_data.significand : in_data.significand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
    if (en) begin
      ctl0_r <= ctl0;
      mag0_r <= mag0;
    end
  end

  assign vld[0] = vld0_r;
  assign ctl[0] = ctl0_r;
  assign mag[0] = mag0_r;
  assign stk[0] = 1'b0;
  assign lst[0] = 4'd0;
  assign ovf[0] = 1'b0;

  for (genvar g = 0; g < NST; g++) begin : g_dig
    drr_digit u_dig (
      .clk, .rst_n, .en,
      .vld_in(vld[g]), .idx(5'(g)), .ctl_in(ctl[g]), .mag_in(mag[g]),
      .sticky_in(stk[g]), .last_in(lst[g]), .ovf_in(ovf[g]),
      .vld_out(vld[g+1]), .ctl_out(ctl[g+1]), .mag_out(mag[g+1]),
      .sticky_out(stk[g+1]), .last_out(lst[g+1]), .ovf_out(ovf[g+1])
    );
  end

  drr_round u_round (
    .ctl(ctl[NST]), .mag(mag[NST]), .sticky(stk[NST]), .last(lst[NST]),
    .ovf(ovf[NST]), .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[NST];
    end
    if (en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

@@ sim/tb_decimal_rescale_rounded.sv @@
// Self-checking testbench for the decimal rescaler with rounding modes.
`timescale 1ns / 100ps
`default_nettype none
module tb_decimal_rescale_rounded;
  import drr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 650;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  drr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  drr_out_t out_data;

  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;
  bit       long_hold = 1'b0;
  int       errors = 0;
  int       quiet_cycles = 0;
  drr_out_t expected_results[$];

  decimal_rescale_rounded DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // Works out the rescaled value of one transaction.
  function automatic drr_out_t rescale(input drr_in_t x);
    drr_out_t r;
    logic signed [32:0] step;
    logic neg, away;
    logic [63:0] mag, f, lim, q, rem, rem2;
    step = {x.target_scale[31], x.target_scale} - {x.scale[31], x.scale};
    neg = x.significand[63];
    mag = neg ? -x.significand : x.significand;
    r.result_significand = x.significand;
    r.result_scale = x.target_scale;
    r.status = ST_OK;
    if (step == 0) begin
    end else if (step > 0 && step < 19) begin
      f = ten_to(int'(step));
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (mag > lim / f) begin
        r.result_significand = lim;
        r.status = ST_SATURATED;
      end else begin
        r.result_significand = neg ? -(mag * f) : mag * f;
      end
    end else if (step < 0 && step > -19) begin
      f = ten_to(int'(-step));
      q = mag / f;
      rem = mag % f;
      rem2 = rem * 2;
      away = 1'b0;
      case (x.rounding_mode)
        RM_UP:        away = rem != 0;
        RM_DOWN:      away = 1'b0;
        RM_CEILING:   away = rem != 0 && !neg;
        RM_FLOOR:     away = rem != 0 && neg;
        RM_HALF_UP:   away = rem2 >= f;
        RM_HALF_DOWN: away = rem2 > f;
        RM_HALF_EVEN: away = rem2 > f || (rem2 == f && q[0]);
        default: begin
          if (rem != 0) begin
            q = 0;
            r.status = ST_INEXACT;
          end
        end
      endcase
      if (away) q = q + 1;
      r.result_significand = neg ? -q : q;
    end else begin
      r.result_scale = x.scale;
      r.status = ST_RANGE;
    end
    return r;
  endfunction

  // Directed rows; has_fixed marks rows whose result is written out by hand.
  typedef struct {
    drr_in_t  item;
    bit       has_fixed;
    drr_out_t fixed;
  } directed_row_t;

  localparam logic signed [63:0] SIG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SIG_MIN = 64'sh8000_0000_0000_0000;

  directed_row_t directed_rows[] = '{
    '{'{64'sd0, 32'sd0, 32'sd0, RM_UP}, 1, '{64'sd0, 32'sd0, ST_OK}},
    '{'{SIG_MAX, 32'sd0, 32'sd0, RM_DOWN}, 1, '{SIG_MAX, 32'sd0, ST_OK}},
    '{'{SIG_MAX, 32'sd0, 32'sd1, RM_UP}, 1, '{SIG_MAX, 32'sd1, ST_SATURATED}},
    '{'{SIG_MIN, 32'sd0, 32'sd18, RM_UP}, 1, '{SIG_MIN, 32'sd18, ST_SATURATED}},
    '{'{64'sd5, 32'sd3, 32'sd22, RM_UP}, 1, '{64'sd5, 32'sd3, ST_RANGE}},
    '{'{64'sd5, 32'sd22, 32'sd3, RM_UP}, 1, '{64'sd5, 32'sd22, ST_RANGE}},
    '{'{-64'sd7, 32'sh7FFF_FFFF, 32'sh8000_0000, RM_DOWN}, 1,
      '{-64'sd7, 32'sh7FFF_FFFF, ST_RANGE}},
    '{'{64'sd7, 32'sh8000_0000, 32'sh7FFF_FFFF, RM_DOWN}, 1,
      '{64'sd7, 32'sh8000_0000, ST_RANGE}},
    '{'{64'sd15, 32'sd1, 32'sd0, RM_UNNECESSARY}, 1, '{64'sd0, 32'sd0, ST_INEXACT}},
    '{'{64'sd20, 32'sd1, 32'sd0, RM_UNNECESSARY}, 1, '{64'sd2, 32'sd0, ST_OK}},
    '{'{64'sd25, 32'sd1, 32'sd0, RM_HALF_UP}, 0, '0},
    '{'{64'sd25, 32'sd1, 32'sd0, RM_HALF_DOWN}, 0, '0},
    '{'{64'sd25, 32'sd1, 32'sd0, RM_HALF_EVEN}, 0, '0},
    '{'{64'sd35, 32'sd1, 32'sd0, RM_HALF_EVEN}, 0, '0},
    '{'{-64'sd25, 32'sd1, 32'sd0, RM_HALF_UP}, 0, '0},
    '{'{-64'sd21, 32'sd1, 32'sd0, RM_CEILING}, 0, '0},
    '{'{-64'sd21, 32'sd1, 32'sd0, RM_FLOOR}, 0, '0},
    '{'{64'sd21, 32'sd1, 32'sd0, RM_CEILING}, 0, '0},
    '{'{64'sd21, 32'sd1, 32'sd0, RM_FLOOR}, 0, '0},
    '{'{-64'sd21, 32'sd1, 32'sd0, RM_UP}, 0, '0},
    '{'{SIG_MIN, 32'sd18, 32'sd0, RM_HALF_EVEN}, 0, '0},
    '{'{SIG_MAX, 32'sd18, 32'sd0, RM_UP}, 0, '0},
    '{'{64'sd922337203685477580, 32'sd0, 32'sd1, RM_UP}, 0, '0},
    '{'{-64'sd922337203685477580, 32'sd0, 32'sd1, RM_UP}, 0, '0},
    '{'{64'sd500000000000000000, 32'sd18, 32'sd0, RM_HALF_EVEN}, 0, '0}
  };

  function automatic drr_in_t random_item();
    drr_in_t x;
    int base, step;
    x.significand = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: x.significand = x.significand >>> $urandom_range(0, 63);
      1: x.significand = $signed(64'($urandom_range(0, 999))) *
                         $signed(ten_to($urandom_range(0, 15)));
      default: ;
    endcase
    if ($urandom_range(0, 1)) x.significand = -x.significand;
    if ($urandom_range(0, 9) == 0) begin
      x.scale = $urandom;
      x.target_scale = $urandom;
    end else begin
      base = $urandom_range(0, 7) == 0 ? int'($urandom) : $urandom_range(0, 40) - 20;
      step = $urandom_range(0, 9) == 0 ? $urandom_range(0, 60) - 30
                                       : $urandom_range(0, 36) - 18;
      x.scale = base;
      x.target_scale = base + step;
    end
    x.rounding_mode = $urandom_range(0, 7);
    return x;
  endfunction

  // Valid is only dropped when the sender idles, so back-to-back transactions
  // keep it high across the accepting edge.
  task automatic send(input drr_in_t x);
    while ($urandom_range(1, 100) <= sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Scoreboard push happens on acceptance so the order matches the pipeline.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_results.push_back(rescale(in_data));
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (long_hold) out_ready <= 1'b0;
      else out_ready <= $urandom_range(1, 100) > receiver_stall_pct;
    end
  end

  always @(posedge clk) begin
    drr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_significand !== want.result_significand) begin
          $error("result_significand: expected %0d, got %0d",
                 want.result_significand, out_data.result_significand);
          errors++;
        end
        if (out_data.result_scale !== want.result_scale) begin
          $error("result_scale: expected %0d, got %0d",
                 want.result_scale, out_data.result_scale);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Fixed expectations are checked against the predictor too, as a table sanity check.
  task automatic run_directed();
    drr_out_t got;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_fixed) begin
        got = rescale(directed_rows[i].item);
        if (got !== directed_rows[i].fixed) begin
          $error("directed row %0d: table %h, predictor %h", i,
                 directed_rows[i].fixed, got);
          errors++;
        end
      end
      send(directed_rows[i].item);
    end
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n) send(random_item());
  endtask

  initial begin
    int wait_cycles;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_phase(RANDOM_ITEMS / 5, 0, 0);
    run_phase(RANDOM_ITEMS / 5, 54, 0);
    run_phase(RANDOM_ITEMS / 5, 0, 54);
    run_phase(RANDOM_ITEMS / 5, 21, 21);
    // Long receiver hold-off while the sender keeps offering, to fill the pipeline.
    fork
      begin
        long_hold = 1'b1;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end
      run_phase(RANDOM_ITEMS / 10, 0, 0);
    join
    run_phase(RANDOM_ITEMS / 10, 0, 0);
    in_valid <= 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hdl/drr_pkg.sv
hdl/drr_digit.sv
hdl/drr_round.sv
hdl/decimal_rescale_rounded.sv
sim/tb_decimal_rescale_rounded.sv
